// ===== rtl/ldfx_pkg.sv =====
// ----------------------------------------------------------------------------
// ldfx_pkg: shared types and constants of the length framed deframer
// Parser phases, queue operation codes, status codes and register indexes.
// ----------------------------------------------------------------------------
package ldfx_pkg;

  // Payload bytes that feed decoded fields (bytes 0 to 23)
  localparam int unsigned FIELD_BYTES = 24;
  localparam int unsigned IDX_W       = $clog2(FIELD_BYTES);

  // Configuration register indexes
  localparam logic [1:0] REG_START_MARKER = 2'd0;
  localparam logic [1:0] REG_END_MARKER   = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

  // Configuration reset values
  localparam logic [7:0] START_MARKER_RST = 8'h02;
  localparam logic [7:0] END_MARKER_RST   = 8'h03;
  localparam logic [5:0] MAX_LENGTH_RST   = 6'd32;

  // Result status codes
  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_OK   = 2'd1;
  localparam logic [1:0] ST_FAIL = 2'd2;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_CHECK,
    PH_END
  } phase_e;

  // Operation handed from front to back, one per beat
  typedef enum logic [1:0] {
    OP_BUSY,   // status busy, store untouched
    OP_STORE,  // status busy, write one payload byte
    OP_FAIL,   // status fail, flush store
    OP_OK      // status ok with decoded fields, flush store
  } op_e;

  typedef struct packed {
    op_e              kind;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } op_t;

endpackage

// ===== rtl/ldfx_front.sv =====
// ----------------------------------------------------------------------------
// ldfx_front: frame parser
// Takes received bytes, tracks the frame phase, length, count and running
// XOR, and turns each beat into one operation for the back end.
// ----------------------------------------------------------------------------
module ldfx_front import ldfx_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // received bytes
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  // operations toward the queue
  output logic       op_valid_o,
  input  logic       op_ready_i,
  output op_t        op_o
);

  localparam logic [7:0] BufLimit = 8'(BUFFER_BYTES);

  logic [7:0] start_marker_q, end_marker_q;
  logic [5:0] max_length_q;

  phase_e     phase_q, phase_d;
  logic [5:0] len_q, len_d;
  logic [5:0] count_q, count_d;
  logic [7:0] xor_q, xor_d;

  logic       push;
  logic [7:0] limit;
  logic [6:0] count_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = op_ready_i;
  assign op_valid_o  = in_valid_i;
  assign push        = in_valid_i & op_ready_i;

  // effective length limit: smaller of register and buffer size
  assign limit     = (BufLimit < {2'b00, max_length_q}) ? BufLimit : {2'b00, max_length_q};
  assign count_inc = {1'b0, count_q} + 7'd1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= START_MARKER_RST;
      end_marker_q   <= END_MARKER_RST;
      max_length_q   <= MAX_LENGTH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_MARKER: start_marker_q <= cfg_data_i;
        REG_END_MARKER:   end_marker_q   <= cfg_data_i;
        REG_MAX_LENGTH:   max_length_q   <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  // next state of the parser
  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    count_d = count_q;
    xor_d   = xor_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == start_marker_q) phase_d = PH_LEN;
      end
      PH_LEN: begin
        if (rx_byte_i > limit) begin
          phase_d = PH_HUNT;
          len_d   = '0;
        end else begin
          len_d   = rx_byte_i[5:0];
          phase_d = (rx_byte_i == 8'd0) ? PH_CHECK : PH_DATA;
        end
        count_d = '0;
        xor_d   = '0;
      end
      PH_DATA: begin
        xor_d   = xor_q ^ rx_byte_i;
        count_d = count_inc[5:0];
        if (count_inc >= {1'b0, len_q}) phase_d = PH_CHECK;
      end
      PH_CHECK: begin
        if (rx_byte_i == xor_q) begin
          phase_d = PH_END;
        end else begin
          phase_d = PH_HUNT;
          len_d   = '0;
          count_d = '0;
          xor_d   = '0;
        end
      end
      PH_END: begin
        phase_d = PH_HUNT;
        len_d   = '0;
        count_d = '0;
        xor_d   = '0;
      end
      default: begin
        phase_d = PH_HUNT;
        len_d   = '0;
        count_d = '0;
        xor_d   = '0;
      end
    endcase
  end

  // operation issued for this beat
  always_comb begin
    op_o.kind = OP_BUSY;
    op_o.idx  = '0;
    op_o.data = '0;
    unique case (phase_q)
      PH_HUNT: op_o.kind = OP_BUSY;
      PH_LEN: begin
        if (rx_byte_i > limit) op_o.kind = OP_FAIL;
      end
      PH_DATA: begin
        // bytes past the decoded fields are never read back
        if (count_q < 6'(FIELD_BYTES)) begin
          op_o.kind = OP_STORE;
          op_o.idx  = count_q[IDX_W-1:0];
          op_o.data = rx_byte_i;
        end
      end
      PH_CHECK: begin
        if (rx_byte_i != xor_q) op_o.kind = OP_FAIL;
      end
      PH_END: op_o.kind = (rx_byte_i == end_marker_q) ? OP_OK : OP_FAIL;
      default: op_o.kind = OP_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= '0;
      count_q <= '0;
      xor_q   <= '0;
    end else if (push) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
      xor_q   <= xor_d;
    end
  end

endmodule

// ===== rtl/ldfx_queue.sv =====
// ----------------------------------------------------------------------------
// ldfx_queue: two-entry operation queue
// Decouples the parser from the result stage so each side stalls on its own.
// ----------------------------------------------------------------------------
module ldfx_queue import ldfx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  op_t        entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;
  logic       push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_op_o     = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  // fill level
  always_comb begin
    fill_d = fill_q;
    priority case (1'b1)
      push & ~pop: fill_d = fill_q + 2'd1;
      pop & ~push: fill_d = fill_q - 2'd1;
      default:     fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= push_op_i;
  end

endmodule

// ===== rtl/ldfx_back.sv =====
// ----------------------------------------------------------------------------
// ldfx_back: payload store and result stage
// Executes queued operations: writes payload bytes, flushes the store and
// registers one result beat per operation with the decoded fields.
// ----------------------------------------------------------------------------
module ldfx_back import ldfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  output logic        op_ready_o,
  input  op_t         op_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] effect_id_o,
  output logic [31:0] duration_o,
  output logic [7:0]  color_first_o,
  output logic [7:0]  color_second_o,
  output logic [7:0]  color_third_o,
  output logic [31:0] frequency_o,
  output logic [31:0] random_seed_o,
  output logic [31:0] flag_bits_o
);

  logic [7:0]  store_q [FIELD_BYTES];
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] effect_id_q, duration_q, frequency_q, random_seed_q, flag_bits_q;
  logic [7:0]  color_first_q, color_second_q, color_third_q;
  logic        take;
  logic        ok_op;

  assign op_ready_o = ~out_valid_q | out_ready_i;
  assign take       = op_valid_i & op_ready_o;
  assign ok_op      = (op_i.kind == OP_OK);

  // payload store: write on store ops, flush at frame end or failure
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(FIELD_BYTES); i++) store_q[i] <= '0;
    end else if (take) begin
      unique case (op_i.kind)
        OP_STORE: store_q[op_i.idx] <= op_i.data;
        OP_FAIL, OP_OK: begin
          for (int i = 0; i < int'(FIELD_BYTES); i++) store_q[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (op_ready_o) begin
      out_valid_q <= op_valid_i;
    end
  end

  // result beat: fields decoded little-endian on success, zero otherwise
  always_ff @(posedge clk_i) begin
    if (take) begin
      effect_id_q    <= ok_op ? {store_q[3], store_q[2], store_q[1], store_q[0]} : '0;
      duration_q     <= ok_op ? {store_q[7], store_q[6], store_q[5], store_q[4]} : '0;
      color_first_q  <= ok_op ? store_q[8] : '0;
      color_second_q <= ok_op ? store_q[9] : '0;
      color_third_q  <= ok_op ? store_q[10] : '0;
      frequency_q    <= ok_op ? {store_q[15], store_q[14], store_q[13], store_q[12]} : '0;
      random_seed_q  <= ok_op ? {store_q[19], store_q[18], store_q[17], store_q[16]} : '0;
      flag_bits_q    <= ok_op ? {store_q[23], store_q[22], store_q[21], store_q[20]} : '0;
      unique case (op_i.kind)
        OP_OK:             status_q <= ST_OK;
        OP_FAIL:           status_q <= ST_FAIL;
        OP_BUSY, OP_STORE: status_q <= ST_BUSY;
        default:           status_q <= ST_BUSY;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign effect_id_o    = effect_id_q;
  assign duration_o     = duration_q;
  assign color_first_o  = color_first_q;
  assign color_second_o = color_second_q;
  assign color_third_o  = color_third_q;
  assign frequency_o    = frequency_q;
  assign random_seed_o  = random_seed_q;
  assign flag_bits_o    = flag_bits_q;

endmodule

// ===== rtl/length_framed_xor_checked_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// length_framed_xor_checked_deframer_unit: start/length/payload/XOR/end deframer
// Every received byte beat produces exactly one result beat carrying a status
// (busy, ok, fail); on ok the decoded payload fields come along.
// ----------------------------------------------------------------------------
// Throughput is one byte per cycle while results drain: the parser updates its
// phase, count and running XOR per accepted byte, issues one operation into a
// two-entry queue, and the result stage retires one operation per cycle into
// its output register while that is free or being read. Each operation is
// registered in the queue, then its result in the output register. The payload
// store is flushed when the result stage takes the end or failure operation of
// a frame, so no clearing pass follows reset. Only payload bytes 0 to 23 are
// kept since nothing past them is ever decoded; BUFFER_BYTES still caps the
// accepted length. Configuration writes are always taken and apply at once.
module length_framed_xor_checked_deframer_unit import ldfx_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] effect_id_o,
  output logic [31:0] duration_o,
  output logic [7:0]  color_first_o,
  output logic [7:0]  color_second_o,
  output logic [7:0]  color_third_o,
  output logic [31:0] frequency_o,
  output logic [31:0] random_seed_o,
  output logic [31:0] flag_bits_o
);

  logic fq_valid, fq_ready;
  op_t  fq_op;
  logic qb_valid, qb_ready;
  op_t  qb_op;

  // parser
  ldfx_front #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .op_valid_o  (fq_valid),
    .op_ready_i  (fq_ready),
    .op_o        (fq_op)
  );

  // operation queue
  ldfx_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_op_i    (fq_op),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_op_o     (qb_op)
  );

  // store and result stage
  ldfx_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (qb_valid),
    .op_ready_o     (qb_ready),
    .op_i           (qb_op),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .effect_id_o    (effect_id_o),
    .duration_o     (duration_o),
    .color_first_o  (color_first_o),
    .color_second_o (color_second_o),
    .color_third_o  (color_third_o),
    .frequency_o    (frequency_o),
    .random_seed_o  (random_seed_o),
    .flag_bits_o    (flag_bits_o)
  );

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for length_framed_xor_checked_deframer_unit
// Drives received bytes and register writes over valid/ready channels with
// random idle bursts on both sides. A byte-level software copy of the parser
// predicts one status beat per byte, and each result beat is compared field
// by field in order of arrival.
// ----------------------------------------------------------------------------
module testbench;
  import ldfx_pkg::*;

  localparam int unsigned BUF_BYTES   = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 245;
  // Index beyond the register file; writes to it must be ignored
  localparam logic [1:0]  REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] effect_id;
    logic [31:0] duration;
    logic [7:0]  color_first;
    logic [7:0]  color_second;
    logic [7:0]  color_third;
    logic [31:0] frequency;
    logic [31:0] random_seed;
    logic [31:0] flag_bits;
  } frame_result_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    logic [1:0] status;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_START_MARKER;
  logic [7:0]  cfg_data_i = 8'h00;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] effect_id_o;
  logic [31:0] duration_o;
  logic [7:0]  color_first_o;
  logic [7:0]  color_second_o;
  logic [7:0]  color_third_o;
  logic [31:0] frequency_o;
  logic [31:0] random_seed_o;
  logic [31:0] flag_bits_o;

  length_framed_xor_checked_deframer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .effect_id_o    (effect_id_o),
    .duration_o     (duration_o),
    .color_first_o  (color_first_o),
    .color_second_o (color_second_o),
    .color_third_o  (color_third_o),
    .frequency_o    (frequency_o),
    .random_seed_o  (random_seed_o),
    .flag_bits_o    (flag_bits_o)
  );

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench state
  frame_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   stall_left = 0;
  bit            idle_on = 1'b1;

  // Predicted register file
  logic [7:0] start_marker = START_MARKER_RST;
  logic [7:0] end_marker   = END_MARKER_RST;
  logic [5:0] max_length   = MAX_LENGTH_RST;

  // Predicted parser state
  phase_e     frm_phase = PH_HUNT;
  logic [5:0] frm_len   = '0;
  logic [5:0] frm_count = '0;
  logic [7:0] frm_xor   = '0;
  logic [7:0] frm_store [BUF_BYTES];

  initial begin
    foreach (frm_store[i]) frm_store[i] = 8'h00;
  end

  function automatic void clear_frame();
    frm_phase = PH_HUNT;
    frm_len   = '0;
    frm_count = '0;
    frm_xor   = '0;
    foreach (frm_store[i]) frm_store[i] = 8'h00;
  endfunction

  function automatic logic [31:0] store_le32(input int unsigned pos);
    return {frm_store[pos+3], frm_store[pos+2], frm_store[pos+1], frm_store[pos]};
  endfunction

  function automatic int unsigned length_limit();
    return (max_length > BUF_BYTES) ? BUF_BYTES : max_length;
  endfunction

  // Advance the parser copy by one byte and return the status beat it gives
  function automatic frame_result_t deframe_step(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    r.status = ST_BUSY;
    case (frm_phase)
      PH_HUNT: begin
        if (b == start_marker) frm_phase = PH_LEN;
      end
      PH_LEN: begin
        if (b > length_limit()) begin
          clear_frame();
          r.status = ST_FAIL;
        end else begin
          frm_len   = b[5:0];
          frm_count = '0;
          frm_xor   = '0;
          frm_phase = (b == 8'h00) ? PH_CHECK : PH_DATA;
        end
      end
      PH_DATA: begin
        if (frm_count < BUF_BYTES) frm_store[frm_count] = b;
        frm_xor   = frm_xor ^ b;
        frm_count = frm_count + 6'd1;
        if (frm_count >= frm_len) frm_phase = PH_CHECK;
      end
      PH_CHECK: begin
        if (b == frm_xor) begin
          frm_phase = PH_END;
        end else begin
          clear_frame();
          r.status = ST_FAIL;
        end
      end
      PH_END: begin
        if (b == end_marker) begin
          r.status       = ST_OK;
          r.effect_id    = store_le32(0);
          r.duration     = store_le32(4);
          r.color_first  = frm_store[8];
          r.color_second = frm_store[9];
          r.color_third  = frm_store[10];
          r.frequency    = store_le32(12);
          r.random_seed  = store_le32(16);
          r.flag_bits    = store_le32(20);
        end else begin
          r.status = ST_FAIL;
        end
        clear_frame();
      end
      default: clear_frame();
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at cycle %0d: %s got %0h expected %0h",
             cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Offer one byte beat; the expectation is queued at acceptance
  task automatic send_byte(input logic [7:0] b, input logic typed,
                           input logic [1:0] typed_status);
    frame_result_t predicted;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = deframe_step(b);
    if (typed) begin
      predicted = '0;
      predicted.status = typed_status;
    end
    pending_results.push_back(predicted);
    bytes_sent++;
  endtask

  // Register write beat; valid is lowered by the caller
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_START_MARKER: start_marker = data;
      REG_END_MARKER:   end_marker   = data;
      REG_MAX_LENGTH:   max_length   = data[5:0];
      default: ;
    endcase
  endtask

  // Quiesce the byte channel, then load a new register setting
  task automatic apply_setting(input logic [7:0] st, input logic [7:0] en,
                               input logic [7:0] ml);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    write_reg(REG_START_MARKER, st);
    write_reg(REG_END_MARKER, en);
    write_reg(REG_UNUSED, 8'($urandom));
    write_reg(REG_MAX_LENGTH, ml);
    cfg_valid_i <= 1'b0;
  endtask

  // One frame with random content, sometimes broken, preceded by line noise
  task automatic send_frame();
    int unsigned limit;
    int unsigned len;
    int unsigned kind;
    int unsigned pick;
    logic [7:0]  b;
    logic [7:0]  chk;
    limit = length_limit();
    repeat ($urandom_range(0, 2)) begin
      b = 8'($urandom);
      if (b == start_marker) b = ~b;
      send_byte(b, 1'b0, ST_BUSY);
    end
    kind = $urandom_range(0, 19);
    send_byte(start_marker, 1'b0, ST_BUSY);
    // truncated frame: junk after the marker
    if (kind == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, ST_BUSY);
      return;
    end
    // length over the limit
    if (kind == 1) begin
      send_byte(8'($urandom_range(limit + 1, 255)), 1'b0, ST_BUSY);
      return;
    end
    pick = $urandom_range(0, 7);
    if (pick == 0)      len = 0;
    else if (pick == 1) len = limit;
    else if (pick == 2) len = $urandom_range(limit / 2, limit);
    else                len = $urandom_range(0, limit);
    send_byte(8'(len), 1'b0, ST_BUSY);
    chk = 8'h00;
    repeat (len) begin
      b = 8'($urandom);
      chk = chk ^ b;
      send_byte(b, 1'b0, ST_BUSY);
    end
    if (kind == 2 || kind == 3) begin
      send_byte(chk ^ 8'($urandom_range(1, 255)), 1'b0, ST_BUSY);
      return;
    end
    send_byte(chk, 1'b0, ST_BUSY);
    b = end_marker;
    if (kind == 4 || kind == 5) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b, 1'b0, ST_BUSY);
  endtask

  task automatic run_traffic(input int unsigned n_bytes);
    int unsigned first;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) send_frame();
  endtask

  // Result side: check accepted beats, then pick next cycle's ready
  always @(posedge clk_i) begin : result_monitor
    frame_result_t got;
    frame_result_t want;
    cycle_count++;
    if (out_valid_o && out_ready_i) begin
      got = '{status_o, effect_id_o, duration_o, color_first_o, color_second_o,
              color_third_o, frequency_o, random_seed_o, flag_bits_o};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat, status", 32'(got.status), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.effect_id !== want.effect_id)
          report_mismatch("effect_id", got.effect_id, want.effect_id);
        if (got.duration !== want.duration)
          report_mismatch("duration", got.duration, want.duration);
        if (got.color_first !== want.color_first)
          report_mismatch("color_first", 32'(got.color_first),
                          32'(want.color_first));
        if (got.color_second !== want.color_second)
          report_mismatch("color_second", 32'(got.color_second),
                          32'(want.color_second));
        if (got.color_third !== want.color_third)
          report_mismatch("color_third", 32'(got.color_third),
                          32'(want.color_third));
        if (got.frequency !== want.frequency)
          report_mismatch("frequency", got.frequency, want.frequency);
        if (got.random_seed !== want.random_seed)
          report_mismatch("random_seed", got.random_seed, want.random_seed);
        if (got.flag_bits !== want.flag_bits)
          report_mismatch("flag_bits", got.flag_bits, want.flag_bits);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8);
    end
    out_ready_i <= (stall_left == 0);
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Stimulus
  initial begin
    stim_row_t steps [22];
    // reset markers: start 02, end 03, max length 32
    steps = '{
      '{8'h00, 1'b1, ST_BUSY},  // noise while hunting
      '{8'hFF, 1'b1, ST_BUSY},
      '{8'h02, 1'b1, ST_BUSY},  // length just over the limit
      '{8'd33, 1'b1, ST_FAIL},
      '{8'h02, 1'b1, ST_BUSY},  // largest length byte
      '{8'hFF, 1'b1, ST_FAIL},
      '{8'h02, 1'b1, ST_BUSY},  // empty payload, checksum 00, all fields zero
      '{8'h00, 1'b1, ST_BUSY},
      '{8'h00, 1'b1, ST_BUSY},
      '{8'h03, 1'b1, ST_OK},
      '{8'h02, 1'b1, ST_BUSY},  // bad checksum
      '{8'h00, 1'b1, ST_BUSY},
      '{8'h01, 1'b1, ST_FAIL},
      '{8'h02, 1'b1, ST_BUSY},  // bad end marker
      '{8'h00, 1'b1, ST_BUSY},
      '{8'h00, 1'b1, ST_BUSY},
      '{8'h04, 1'b1, ST_FAIL},
      '{8'h02, 1'b0, ST_BUSY},  // one-byte payload, rest of store reads zero
      '{8'h01, 1'b0, ST_BUSY},
      '{8'hFF, 1'b0, ST_BUSY},
      '{8'hFF, 1'b0, ST_BUSY},
      '{8'h03, 1'b0, ST_BUSY}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) send_byte(steps[i].rx, steps[i].typed, steps[i].status);
    run_traffic(200);

    // extremes: limit zero, then limit capped by the buffer size
    apply_setting(8'h00, 8'hFF, 8'h00);
    run_traffic(PHASE_BYTES);
    apply_setting(8'hFF, 8'h00, 8'hFF);
    run_traffic(PHASE_BYTES);
    // same byte opens and closes a frame
    apply_setting(8'h7E, 8'h7E, 8'd24);
    run_traffic(PHASE_BYTES);
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(PHASE_BYTES);
    // closing stretch without idling
    idle_on = 1'b0;
    apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 32)));
    run_traffic(PHASE_BYTES);

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
